[hw/rtl/hpack_pkg.sv]
// Package: Huffman code table, state codes and constants for the HPACK string encoder.
package hpack_pkg;

   localparam int AccBits   = 40;
   localparam int EmitLimit = 32;
   localparam int ByteBits  = 8;

   typedef logic [AccBits-1:0] acc_type;
   typedef logic [5:0]         free_type;
   typedef logic [29:0]        code_type;
   typedef logic [4:0]         len_type;

   typedef struct packed {
      code_type code;
      len_type  len;
   } rom_word_type;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_PACK = 3'd1;
   localparam logic [2:0] ST_EMIT = 3'd2;
   localparam logic [2:0] ST_END  = 3'd3;

   function automatic rom_word_type huff_code(input logic [7:0] sym);
      rom_word_type w;
      w = '0;
      case (sym)
         8'd0: w = {30'h1ff8, 5'd13};       8'd1: w = {30'h7fffd8, 5'd23};
         8'd2: w = {30'hfffffe2, 5'd28};    8'd3: w = {30'hfffffe3, 5'd28};
         8'd4: w = {30'hfffffe4, 5'd28};    8'd5: w = {30'hfffffe5, 5'd28};
         8'd6: w = {30'hfffffe6, 5'd28};    8'd7: w = {30'hfffffe7, 5'd28};
         8'd8: w = {30'hfffffe8, 5'd28};    8'd9: w = {30'hffffea, 5'd24};
         8'd10: w = {30'h3ffffffc, 5'd30};  8'd11: w = {30'hfffffe9, 5'd28};
         8'd12: w = {30'hfffffea, 5'd28};   8'd13: w = {30'h3ffffffd, 5'd30};
         8'd14: w = {30'hfffffeb, 5'd28};   8'd15: w = {30'hfffffec, 5'd28};
         8'd16: w = {30'hfffffed, 5'd28};   8'd17: w = {30'hfffffee, 5'd28};
         8'd18: w = {30'hfffffef, 5'd28};   8'd19: w = {30'hffffff0, 5'd28};
         8'd20: w = {30'hffffff1, 5'd28};   8'd21: w = {30'hffffff2, 5'd28};
         8'd22: w = {30'h3ffffffe, 5'd30};  8'd23: w = {30'hffffff3, 5'd28};
         8'd24: w = {30'hffffff4, 5'd28};   8'd25: w = {30'hffffff5, 5'd28};
         8'd26: w = {30'hffffff6, 5'd28};   8'd27: w = {30'hffffff7, 5'd28};
         8'd28: w = {30'hffffff8, 5'd28};   8'd29: w = {30'hffffff9, 5'd28};
         8'd30: w = {30'hffffffa, 5'd28};   8'd31: w = {30'hffffffb, 5'd28};
         8'd32: w = {30'h14, 5'd6};         8'd33: w = {30'h3f8, 5'd10};
         8'd34: w = {30'h3f9, 5'd10};       8'd35: w = {30'hffa, 5'd12};
         8'd36: w = {30'h1ff9, 5'd13};      8'd37: w = {30'h15, 5'd6};
         8'd38: w = {30'hf8, 5'd8};         8'd39: w = {30'h7fa, 5'd11};
         8'd40: w = {30'h3fa, 5'd10};       8'd41: w = {30'h3fb, 5'd10};
         8'd42: w = {30'hf9, 5'd8};         8'd43: w = {30'h7fb, 5'd11};
         8'd44: w = {30'hfa, 5'd8};         8'd45: w = {30'h16, 5'd6};
         8'd46: w = {30'h17, 5'd6};         8'd47: w = {30'h18, 5'd6};
         8'd48: w = {30'h0, 5'd5};          8'd49: w = {30'h1, 5'd5};
         8'd50: w = {30'h2, 5'd5};          8'd51: w = {30'h19, 5'd6};
         8'd52: w = {30'h1a, 5'd6};         8'd53: w = {30'h1b, 5'd6};
         8'd54: w = {30'h1c, 5'd6};         8'd55: w = {30'h1d, 5'd6};
         8'd56: w = {30'h1e, 5'd6};         8'd57: w = {30'h1f, 5'd6};
         8'd58: w = {30'h5c, 5'd7};         8'd59: w = {30'hfb, 5'd8};
         8'd60: w = {30'h7ffc, 5'd15};      8'd61: w = {30'h20, 5'd6};
         8'd62: w = {30'hffb, 5'd12};       8'd63: w = {30'h3fc, 5'd10};
         8'd64: w = {30'h1ffa, 5'd13};      8'd65: w = {30'h21, 5'd6};
         8'd66: w = {30'h5d, 5'd7};         8'd67: w = {30'h5e, 5'd7};
         8'd68: w = {30'h5f, 5'd7};         8'd69: w = {30'h60, 5'd7};
         8'd70: w = {30'h61, 5'd7};         8'd71: w = {30'h62, 5'd7};
         8'd72: w = {30'h63, 5'd7};         8'd73: w = {30'h64, 5'd7};
         8'd74: w = {30'h65, 5'd7};         8'd75: w = {30'h66, 5'd7};
         8'd76: w = {30'h67, 5'd7};         8'd77: w = {30'h68, 5'd7};
         8'd78: w = {30'h69, 5'd7};         8'd79: w = {30'h6a, 5'd7};
         8'd80: w = {30'h6b, 5'd7};         8'd81: w = {30'h6c, 5'd7};
         8'd82: w = {30'h6d, 5'd7};         8'd83: w = {30'h6e, 5'd7};
         8'd84: w = {30'h6f, 5'd7};         8'd85: w = {30'h70, 5'd7};
         8'd86: w = {30'h71, 5'd7};         8'd87: w = {30'h72, 5'd7};
         8'd88: w = {30'hfc, 5'd8};         8'd89: w = {30'h73, 5'd7};
         8'd90: w = {30'hfd, 5'd8};         8'd91: w = {30'h1ffb, 5'd13};
         8'd92: w = {30'h7fff0, 5'd19};     8'd93: w = {30'h1ffc, 5'd13};
         8'd94: w = {30'h3ffc, 5'd14};      8'd95: w = {30'h22, 5'd6};
         8'd96: w = {30'h7ffd, 5'd15};      8'd97: w = {30'h3, 5'd5};
         8'd98: w = {30'h23, 5'd6};         8'd99: w = {30'h4, 5'd5};
         8'd100: w = {30'h24, 5'd6};        8'd101: w = {30'h5, 5'd5};
         8'd102: w = {30'h25, 5'd6};        8'd103: w = {30'h26, 5'd6};
         8'd104: w = {30'h27, 5'd6};        8'd105: w = {30'h6, 5'd5};
         8'd106: w = {30'h74, 5'd7};        8'd107: w = {30'h75, 5'd7};
         8'd108: w = {30'h28, 5'd6};        8'd109: w = {30'h29, 5'd6};
         8'd110: w = {30'h2a, 5'd6};        8'd111: w = {30'h7, 5'd5};
         8'd112: w = {30'h2b, 5'd6};        8'd113: w = {30'h76, 5'd7};
         8'd114: w = {30'h2c, 5'd6};        8'd115: w = {30'h8, 5'd5};
         8'd116: w = {30'h9, 5'd5};         8'd117: w = {30'h2d, 5'd6};
         8'd118: w = {30'h77, 5'd7};        8'd119: w = {30'h78, 5'd7};
         8'd120: w = {30'h79, 5'd7};        8'd121: w = {30'h7a, 5'd7};
         8'd122: w = {30'h7b, 5'd7};        8'd123: w = {30'h7ffe, 5'd15};
         8'd124: w = {30'h7fc, 5'd11};      8'd125: w = {30'h3ffd, 5'd14};
         8'd126: w = {30'h1ffd, 5'd13};     8'd127: w = {30'hffffffc, 5'd28};
         8'd128: w = {30'hfffe6, 5'd20};    8'd129: w = {30'h3fffd2, 5'd22};
         8'd130: w = {30'hfffe7, 5'd20};    8'd131: w = {30'hfffe8, 5'd20};
         8'd132: w = {30'h3fffd3, 5'd22};   8'd133: w = {30'h3fffd4, 5'd22};
         8'd134: w = {30'h3fffd5, 5'd22};   8'd135: w = {30'h7fffd9, 5'd23};
         8'd136: w = {30'h3fffd6, 5'd22};   8'd137: w = {30'h7fffda, 5'd23};
         8'd138: w = {30'h7fffdb, 5'd23};   8'd139: w = {30'h7fffdc, 5'd23};
         8'd140: w = {30'h7fffdd, 5'd23};   8'd141: w = {30'h7fffde, 5'd23};
         8'd142: w = {30'hffffeb, 5'd24};   8'd143: w = {30'h7fffdf, 5'd23};
         8'd144: w = {30'hffffec, 5'd24};   8'd145: w = {30'hffffed, 5'd24};
         8'd146: w = {30'h3fffd7, 5'd22};   8'd147: w = {30'h7fffe0, 5'd23};
         8'd148: w = {30'hffffee, 5'd24};   8'd149: w = {30'h7fffe1, 5'd23};
         8'd150: w = {30'h7fffe2, 5'd23};   8'd151: w = {30'h7fffe3, 5'd23};
         8'd152: w = {30'h7fffe4, 5'd23};   8'd153: w = {30'h1fffdc, 5'd21};
         8'd154: w = {30'h3fffd8, 5'd22};   8'd155: w = {30'h7fffe5, 5'd23};
         8'd156: w = {30'h3fffd9, 5'd22};   8'd157: w = {30'h7fffe6, 5'd23};
         8'd158: w = {30'h7fffe7, 5'd23};   8'd159: w = {30'hffffef, 5'd24};
         8'd160: w = {30'h3fffda, 5'd22};   8'd161: w = {30'h1fffdd, 5'd21};
         8'd162: w = {30'hfffe9, 5'd20};    8'd163: w = {30'h3fffdb, 5'd22};
         8'd164: w = {30'h3fffdc, 5'd22};   8'd165: w = {30'h7fffe8, 5'd23};
         8'd166: w = {30'h7fffe9, 5'd23};   8'd167: w = {30'h1fffde, 5'd21};
         8'd168: w = {30'h7fffea, 5'd23};   8'd169: w = {30'h3fffdd, 5'd22};
         8'd170: w = {30'h3fffde, 5'd22};   8'd171: w = {30'hfffff0, 5'd24};
         8'd172: w = {30'h1fffdf, 5'd21};   8'd173: w = {30'h3fffdf, 5'd22};
         8'd174: w = {30'h7fffeb, 5'd23};   8'd175: w = {30'h7fffec, 5'd23};
         8'd176: w = {30'h1fffe0, 5'd21};   8'd177: w = {30'h1fffe1, 5'd21};
         8'd178: w = {30'h3fffe0, 5'd22};   8'd179: w = {30'h1fffe2, 5'd21};
         8'd180: w = {30'h7fffed, 5'd23};   8'd181: w = {30'h3fffe1, 5'd22};
         8'd182: w = {30'h7fffee, 5'd23};   8'd183: w = {30'h7fffef, 5'd23};
         8'd184: w = {30'hfffea, 5'd20};    8'd185: w = {30'h3fffe2, 5'd22};
         8'd186: w = {30'h3fffe3, 5'd22};   8'd187: w = {30'h3fffe4, 5'd22};
         8'd188: w = {30'h7ffff0, 5'd23};   8'd189: w = {30'h3fffe5, 5'd22};
         8'd190: w = {30'h3fffe6, 5'd22};   8'd191: w = {30'h7ffff1, 5'd23};
         8'd192: w = {30'h3ffffe0, 5'd26};  8'd193: w = {30'h3ffffe1, 5'd26};
         8'd194: w = {30'hfffeb, 5'd20};    8'd195: w = {30'h7fff1, 5'd19};
         8'd196: w = {30'h3fffe7, 5'd22};   8'd197: w = {30'h7ffff2, 5'd23};
         8'd198: w = {30'h3fffe8, 5'd22};   8'd199: w = {30'h1ffffec, 5'd25};
         8'd200: w = {30'h3ffffe2, 5'd26};  8'd201: w = {30'h3ffffe3, 5'd26};
         8'd202: w = {30'h3ffffe4, 5'd26};  8'd203: w = {30'h7ffffde, 5'd27};
         8'd204: w = {30'h7ffffdf, 5'd27};  8'd205: w = {30'h3ffffe5, 5'd26};
         8'd206: w = {30'hfffff1, 5'd24};   8'd207: w = {30'h1ffffed, 5'd25};
         8'd208: w = {30'h7fff2, 5'd19};    8'd209: w = {30'h1fffe3, 5'd21};
         8'd210: w = {30'h3ffffe6, 5'd26};  8'd211: w = {30'h7ffffe0, 5'd27};
         8'd212: w = {30'h7ffffe1, 5'd27};  8'd213: w = {30'h3ffffe7, 5'd26};
         8'd214: w = {30'h7ffffe2, 5'd27};  8'd215: w = {30'hfffff2, 5'd24};
         8'd216: w = {30'h1fffe4, 5'd21};   8'd217: w = {30'h1fffe5, 5'd21};
         8'd218: w = {30'h3ffffe8, 5'd26};  8'd219: w = {30'h3ffffe9, 5'd26};
         8'd220: w = {30'hffffffd, 5'd28};  8'd221: w = {30'h7ffffe3, 5'd27};
         8'd222: w = {30'h7ffffe4, 5'd27};  8'd223: w = {30'h7ffffe5, 5'd27};
         8'd224: w = {30'hfffec, 5'd20};    8'd225: w = {30'hfffff3, 5'd24};
         8'd226: w = {30'hfffed, 5'd20};    8'd227: w = {30'h1fffe6, 5'd21};
         8'd228: w = {30'h3fffe9, 5'd22};   8'd229: w = {30'h1fffe7, 5'd21};
         8'd230: w = {30'h1fffe8, 5'd21};   8'd231: w = {30'h7ffff3, 5'd23};
         8'd232: w = {30'h3fffea, 5'd22};   8'd233: w = {30'h3fffeb, 5'd22};
         8'd234: w = {30'h1ffffee, 5'd25};  8'd235: w = {30'h1ffffef, 5'd25};
         8'd236: w = {30'hfffff4, 5'd24};   8'd237: w = {30'hfffff5, 5'd24};
         8'd238: w = {30'h3ffffea, 5'd26};  8'd239: w = {30'h7ffff4, 5'd23};
         8'd240: w = {30'h3ffffeb, 5'd26};  8'd241: w = {30'h7ffffe6, 5'd27};
         8'd242: w = {30'h3ffffec, 5'd26};  8'd243: w = {30'h3ffffed, 5'd26};
         8'd244: w = {30'h7ffffe7, 5'd27};  8'd245: w = {30'h7ffffe8, 5'd27};
         8'd246: w = {30'h7ffffe9, 5'd27};  8'd247: w = {30'h7ffffea, 5'd27};
         8'd248: w = {30'h7ffffeb, 5'd27};  8'd249: w = {30'hffffffe, 5'd28};
         8'd250: w = {30'h7ffffec, 5'd27};  8'd251: w = {30'h7ffffed, 5'd27};
         8'd252: w = {30'h7ffffee, 5'd27};  8'd253: w = {30'h7ffffef, 5'd27};
         8'd254: w = {30'h7fffff0, 5'd27};  8'd255: w = {30'h3ffffee, 5'd26};
         default: w = '0;
      endcase
      return w;
   endfunction

endpackage

[hw/rtl/hpack_if.sv]
// Interfaces: request and response channels of the HPACK string encoder.
interface hpack_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  symbol;
   logic        end_of_string;
   logic [15:0] room_bytes;
   modport source (output valid, symbol, end_of_string, room_bytes, input ready);
   modport sink (input valid, symbol, end_of_string, room_bytes, output ready);
endinterface

interface hpack_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       string_done;
   logic       overflow;
   logic       run_last;
   modport source (output valid, out_byte, string_done, overflow, run_last, input ready);
   modport sink (input valid, out_byte, string_done, overflow, run_last, output ready);
endinterface

[hw/rtl/hpack_code_rom.sv]
// Synchronous Huffman code ROM with registered read.
module hpack_code_rom (
   input  logic                    clock,
   input  logic                    rd_en,
   input  logic [7:0]              rd_addr,
   output hpack_pkg::rom_word_type rd_data
);
   import hpack_pkg::*;

   rom_word_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= huff_code(rd_addr);
      end
   end

   assign rd_data = rd_data_ff;
endmodule

[hw/rtl/hpack_huffman_string_encoder_unit.sv]
// Top level: HPACK Huffman string encoder, ROM lookup, bit packer and byte emitter.
//  channel | dir | payload                                         | accepted when
//  req_    | in  | symbol, end_of_string, room_bytes               | valid && ready
//  rsp_    | out | out_byte, string_done, overflow, run_last       | valid && ready
// A request steps through accept, ROM read and pack, the emit steps (one byte sent per
// step while packing, up to 4) and one emit check, then the end step, which registers
// the pad or overflow response at end of string; a dropped request skips the emit steps.
// Reset is synchronous; it clears the sequencer, the packer and the response valid flag.
// A stalled response holds the emitter and the end step; the next request waits until the sequencer is idle.
module hpack_huffman_string_encoder_unit #(
   parameter int ROOM_WIDTH = 16
) (
   input logic       clock,
   input logic       reset,
   hpack_req_if.sink   req_chan,
   hpack_rsp_if.source rsp_chan
);
   import hpack_pkg::*;

   logic [2:0]            state_ff, state_in;
   acc_type               acc_ff, acc_in;
   free_type              free_ff, free_in;
   logic [ROOM_WIDTH-1:0] room_ff, room_in;
   logic                  in_string_ff, in_string_in;
   logic                  discard_ff, discard_in;
   logic                  eos_ff, eos_in;
   logic                  sent_ff, sent_in;
   logic                  ovalid_ff, ovalid_in;
   logic [7:0]            obyte_ff, obyte_in;
   logic                  odone_ff, odone_in;
   logic                  oovf_ff, oovf_in;
   logic                  olast_ff, olast_in;

   rom_word_type          rom_data;
   logic                  accept;
   logic                  slot_free;
   logic [5:0]            shamt;
   free_type              free_next;
   logic [ROOM_WIDTH-1:0] room_next;
   logic                  more_bytes;
   logic                  further;
   acc_type               padded;

   assign accept    = req_chan.valid && req_chan.ready;
   assign slot_free = !ovalid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);

   hpack_code_rom u_rom (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (req_chan.symbol),
      .rd_data (rom_data)
   );

   assign shamt      = free_ff - 6'(rom_data.len);
   assign free_next  = free_ff + 6'(ByteBits);
   assign room_next  = room_ff - ROOM_WIDTH'(1);
   assign more_bytes = (free_next <= 6'(EmitLimit)) && (room_next > ROOM_WIDTH'(1));
   assign further    = more_bytes || (eos_ff && (free_next != 6'(AccBits)));
   assign padded     = acc_ff | ~({AccBits{1'b1}} << free_ff);

   always_comb begin
      state_in     = state_ff;
      acc_in       = acc_ff;
      free_in      = free_ff;
      room_in      = room_ff;
      in_string_in = in_string_ff;
      discard_in   = discard_ff;
      eos_in       = eos_ff;
      sent_in      = sent_ff;
      ovalid_in    = ovalid_ff && !rsp_chan.ready;
      obyte_in     = obyte_ff;
      odone_in     = odone_ff;
      oovf_in      = oovf_ff;
      olast_in     = olast_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               eos_in  = req_chan.end_of_string;
               sent_in = 1'b0;
               if (!in_string_ff) begin
                  in_string_in = 1'b1;
                  acc_in       = '0;
                  free_in      = 6'(AccBits);
                  room_in      = ROOM_WIDTH'(req_chan.room_bytes);
                  discard_in   = 1'b0;
               end
               state_in = ST_PACK;
            end
         end
         ST_PACK: begin
            if (discard_ff) begin
               state_in = ST_END;
            end else begin
               acc_in   = acc_ff | (AccBits'(rom_data.code) << shamt);
               free_in  = shamt;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (free_ff > 6'(EmitLimit)) begin
               state_in = ST_END;
            end else if (room_ff <= ROOM_WIDTH'(1)) begin
               discard_in = 1'b1;
               state_in   = ST_END;
            end else if (slot_free) begin
               ovalid_in = 1'b1;
               obyte_in  = acc_ff[AccBits-1 -: 8];
               odone_in  = eos_ff && (free_next == 6'(AccBits));
               oovf_in   = 1'b0;
               olast_in  = !further;
               sent_in   = 1'b1;
               acc_in    = acc_ff << ByteBits;
               free_in   = free_next;
               room_in   = room_next;
            end
         end
         ST_END: begin
            if (!eos_ff) begin
               state_in = ST_IDLE;
            end else if (discard_ff || free_ff != 6'(AccBits) || !sent_ff) begin
               if (slot_free) begin
                  ovalid_in = 1'b1;
                  odone_in  = 1'b1;
                  olast_in  = 1'b1;
                  if (discard_ff || (free_ff != 6'(AccBits) && room_ff == '0)) begin
                     obyte_in = 8'd0;
                     oovf_in  = 1'b1;
                  end else if (free_ff != 6'(AccBits)) begin
                     obyte_in = padded[AccBits-1 -: 8];
                     oovf_in  = 1'b0;
                  end else begin
                     obyte_in = 8'd0;
                     oovf_in  = 1'b0;
                  end
                  in_string_in = 1'b0;
                  discard_in   = 1'b0;
                  acc_in       = '0;
                  free_in      = 6'(AccBits);
                  state_in     = ST_IDLE;
               end
            end else begin
               in_string_in = 1'b0;
               discard_in   = 1'b0;
               acc_in       = '0;
               free_in      = 6'(AccBits);
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         acc_ff       <= '0;
         free_ff      <= 6'(AccBits);
         room_ff      <= '0;
         in_string_ff <= 1'b0;
         discard_ff   <= 1'b0;
         ovalid_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         free_ff      <= free_in;
         room_ff      <= room_in;
         in_string_ff <= in_string_in;
         discard_ff   <= discard_in;
         ovalid_ff    <= ovalid_in;
      end
      eos_ff   <= eos_in;
      sent_ff  <= sent_in;
      obyte_ff <= obyte_in;
      odone_ff <= odone_in;
      oovf_ff  <= oovf_in;
      olast_ff <= olast_in;
   end

   assign rsp_chan.valid       = ovalid_ff;
   assign rsp_chan.out_byte    = obyte_ff;
   assign rsp_chan.string_done = odone_ff;
   assign rsp_chan.overflow    = oovf_ff;
   assign rsp_chan.run_last    = olast_ff;
endmodule
